### hdl/lbmd_pkg.sv
package lbmd_pkg;

    // Fixed field widths of the item and result words
    localparam int REQ_W   = 3;
    localparam int POS_W   = 6;
    localparam int COLOR_W = 24;
    localparam int LEVEL_W = 16;
    localparam int BRIGHT_W = 8;
    localparam int EXT_W   = 32;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int MODE_W  = 3;
    localparam int OFFS_W  = 8;

    localparam logic REG_DISPLAY_MODE      = 1'b0;
    localparam logic REG_BRIGHTNESS_OFFSET = 1'b1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_FRAME      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_THRESHOLD  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_BACKGROUND = 3'd2;
    localparam logic [REQ_W-1:0] REQ_BAR        = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DOT        = 3'd4;

    // Display modes
    localparam logic [MODE_W-1:0] MODE_PPM_DOT_VU_BAR = 3'd0;
    localparam logic [MODE_W-1:0] MODE_VU_BAR         = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VU_DOT         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PPM_BAR        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PPM_DOT        = 3'd4;

    localparam logic [9:0] BASE_BRIGHTNESS = 10'd127;

    // Lane order
    localparam int LANE_VU_L  = 0;
    localparam int LANE_VU_R  = 1;
    localparam int LANE_PPM_L = 2;
    localparam int LANE_PPM_R = 3;
    localparam int NUM_LANES  = 4;

    typedef struct packed {
        logic start;
        logic step;
    } lane_ctl_t;

endpackage

### hdl/led_bargraph_meter_drive.sv
// Stereo LED bargraph driver. Load words (req_type 1..4) write one threshold or
// colour entry and give no result; loads with table_index at or beyond
// NUM_LEDS and unknown request codes are dropped. A level frame sweeps the
// threshold memory, one entry a cycle, with four comparison lanes (VU/PPM,
// left/right) working on it side by side, then streams NUM_LEDS results, one
// LED position a cycle while out_stall is low, read from the colour memories
// through a two-stage pipeline. The single read port of each table memory
// sets the pace of a frame; in_stall stays high throughout. All four tables
// must be loaded before the first frame. display_mode and brightness_offset
// are to be written over the APB port only while the block is idle; the block
// itself does not enforce this. display_mode codes 5..7 draw as mode 0.
module led_bargraph_meter_drive #(
    parameter int NUM_LEDS   = 36,
    parameter int LEVEL_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lbmd_pkg::PADDR_W-1:0]      paddr,
    input  logic [lbmd_pkg::PDATA_W-1:0]      pwdata,
    output logic [lbmd_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lbmd_pkg::REQ_W-1:0]        req_type,
    input  logic [lbmd_pkg::POS_W-1:0]        table_index,
    input  logic [lbmd_pkg::COLOR_W-1:0]      load_word,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] vu_left,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] vu_right,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] ppm_left,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] ppm_right,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lbmd_pkg::POS_W-1:0]        led_position,
    output logic [lbmd_pkg::COLOR_W-1:0]      color_left,
    output logic [lbmd_pkg::COLOR_W-1:0]      color_right,
    output logic [lbmd_pkg::BRIGHT_W-1:0]     global_brightness,
    output logic                              last_led
);

    import lbmd_pkg::*;

    localparam int PW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int CW = $clog2(NUM_LEDS + 1);
    localparam logic [CW-1:0]    N_CW   = CW'(NUM_LEDS);
    localparam logic [PW-1:0]    LAST_P = PW'(NUM_LEDS - 1);
    localparam logic [POS_W:0]   N_IDX  = (POS_W + 1)'(NUM_LEDS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    // Configuration
    logic [MODE_W-1:0]        mode_reg;
    logic signed [OFFS_W-1:0] boff_reg;
    logic                     cfg_wr;
    logic [9:0]               bright_sum;
    logic [BRIGHT_W-1:0]      bright;

    // Control
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] fp_reg, fp_next;
    logic          thr_vld_reg;
    logic          thr_re;
    logic          fetch;
    logic          d_vld_reg;
    logic [PW-1:0] d_pos_reg;
    logic          out_free;
    logic          acc;
    logic          frame_acc;
    logic          idx_ok;
    logic [PW-1:0] waddr;

    // Data
    logic [EXT_W-1:0]      word_ext;
    logic [EXT_W-1:0]      lvl_ext [NUM_LANES];
    logic [LEVEL_BITS-1:0] thr_wdata;
    logic [LEVEL_BITS-1:0] thr_rdata;
    logic [COLOR_W-1:0]    bg_rdata, bar_rdata, dot_rdata;
    logic [CW-1:0]         lane_count [NUM_LANES];
    lane_ctl_t             lane_ctl;
    logic [COLOR_W-1:0]    mcl, mcr;

    logic                  out_valid_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [COLOR_W-1:0]    cl_reg, cr_reg;
    logic [BRIGHT_W-1:0]   bright_reg;
    logic                  last_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PPM_DOT_VU_BAR;
            boff_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_DISPLAY_MODE:      mode_reg <= pwdata[MODE_W-1:0];
                REG_BRIGHTNESS_OFFSET: boff_reg <= pwdata[OFFS_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DISPLAY_MODE:      prdata = PDATA_W'(mode_reg);
            REG_BRIGHTNESS_OFFSET: prdata = PDATA_W'($unsigned(boff_reg));
            default:               prdata = '0;
        endcase
    end

    // 127 + offset, clamped at 0
    assign bright_sum = BASE_BRIGHTNESS + {{2{boff_reg[OFFS_W-1]}}, boff_reg};
    assign bright     = bright_sum[9] ? '0 :
                        (bright_sum[8] ? '1 : bright_sum[7:0]);

    // ---------------- input side ----------------
    assign in_stall  = (state_reg != ST_IDLE);
    assign acc       = in_valid && !in_stall;
    assign frame_acc = acc && (req_type == REQ_FRAME);
    assign idx_ok    = {1'b0, table_index} < N_IDX;
    assign waddr     = table_index[PW-1:0];

    assign word_ext  = EXT_W'(load_word);
    assign thr_wdata = word_ext[LEVEL_BITS-1:0];

    assign lvl_ext[LANE_VU_L]  = EXT_W'($unsigned(vu_left));
    assign lvl_ext[LANE_VU_R]  = EXT_W'($unsigned(vu_right));
    assign lvl_ext[LANE_PPM_L] = EXT_W'($unsigned(ppm_left));
    assign lvl_ext[LANE_PPM_R] = EXT_W'($unsigned(ppm_right));

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        fp_next    = fp_reg;
        thr_re     = 1'b0;
        fetch      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_acc)
                begin
                    state_next = ST_SWEEP;
                    fp_next    = '0;
                end
            end
            ST_SWEEP:
            begin
                if (fp_reg != N_CW)
                begin
                    thr_re  = 1'b1;
                    fp_next = fp_reg + CW'(1);
                end
                else
                begin
                    // last threshold lands in the lanes at this edge
                    state_next = ST_EMIT;
                    fp_next    = '0;
                end
            end
            ST_EMIT:
            begin
                if (out_free && (fp_reg != N_CW))
                begin
                    fetch   = 1'b1;
                    fp_next = fp_reg + CW'(1);
                end
                if ((fp_reg == N_CW) && !d_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fp_reg        <= '0;
            thr_vld_reg   <= 1'b0;
            d_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fp_reg      <= fp_next;
            thr_vld_reg <= thr_re;
            if (out_free)
            begin
                d_vld_reg     <= fetch;
                out_valid_reg <= d_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            d_pos_reg  <= fp_reg[PW-1:0];
            pos_reg    <= POS_W'(d_pos_reg);
            cl_reg     <= mcl;
            cr_reg     <= mcr;
            bright_reg <= bright;
            last_reg   <= (d_pos_reg == LAST_P);
        end
    end

    // ---------------- table memories ----------------
    lbmd_ram #(.WIDTH(LEVEL_BITS), .DEPTH(NUM_LEDS)) u_thr_ram (
        .clk   (clk),
        .we    (acc && idx_ok && (req_type == REQ_THRESHOLD)),
        .waddr (waddr),
        .wdata (thr_wdata),
        .re    (thr_re),
        .raddr (fp_reg[PW-1:0]),
        .rdata (thr_rdata)
    );

    lbmd_ram #(.WIDTH(COLOR_W), .DEPTH(NUM_LEDS)) u_bg_ram (
        .clk   (clk),
        .we    (acc && idx_ok && (req_type == REQ_BACKGROUND)),
        .waddr (waddr),
        .wdata (load_word),
        .re    (fetch),
        .raddr (fp_reg[PW-1:0]),
        .rdata (bg_rdata)
    );

    lbmd_ram #(.WIDTH(COLOR_W), .DEPTH(NUM_LEDS)) u_bar_ram (
        .clk   (clk),
        .we    (acc && idx_ok && (req_type == REQ_BAR)),
        .waddr (waddr),
        .wdata (load_word),
        .re    (fetch),
        .raddr (fp_reg[PW-1:0]),
        .rdata (bar_rdata)
    );

    lbmd_ram #(.WIDTH(COLOR_W), .DEPTH(NUM_LEDS)) u_dot_ram (
        .clk   (clk),
        .we    (acc && idx_ok && (req_type == REQ_DOT)),
        .waddr (waddr),
        .wdata (load_word),
        .re    (fetch),
        .raddr (fp_reg[PW-1:0]),
        .rdata (dot_rdata)
    );

    // ---------------- comparison lanes ----------------
    assign lane_ctl.start = frame_acc;
    assign lane_ctl.step  = thr_vld_reg;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        lbmd_lane #(.NUM_LEDS(NUM_LEDS), .LEVEL_BITS(LEVEL_BITS)) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl),
            .level ($signed(lvl_ext[g][LEVEL_BITS-1:0])),
            .thr   ($signed(thr_rdata)),
            .count (lane_count[g])
        );
    end

    // ---------------- merge ----------------
    lbmd_merge #(.NUM_LEDS(NUM_LEDS)) u_merge (
        .mode        (mode_reg),
        .vu_l        (lane_count[LANE_VU_L]),
        .vu_r        (lane_count[LANE_VU_R]),
        .ppm_l       (lane_count[LANE_PPM_L]),
        .ppm_r       (lane_count[LANE_PPM_R]),
        .pos         (d_pos_reg),
        .bg          (bg_rdata),
        .bar         (bar_rdata),
        .dot         (dot_rdata),
        .color_left  (mcl),
        .color_right (mcr)
    );

    assign out_valid         = out_valid_reg;
    assign led_position      = pos_reg;
    assign color_left        = cl_reg;
    assign color_right       = cr_reg;
    assign global_brightness = bright_reg;
    assign last_led          = last_reg;

`ifndef SYNTHESIS
    a_frame_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        frame_acc |=> (state_reg == ST_SWEEP))
        else $error("frame word did not start a threshold sweep");

    a_step_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        thr_vld_reg |-> (state_reg == ST_SWEEP))
        else $error("threshold step outside the sweep");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !d_vld_reg)
        else $error("colour pipeline not drained in idle");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_led) |-> (led_position == POS_W'(NUM_LEDS - 1)))
        else $error("last_led flagged on a wrong position");
`endif

endmodule

### hdl/lbmd_ram.sv
module lbmd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 36
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lbmd_lane.sv
module lbmd_lane #(
    parameter int NUM_LEDS   = 36,
    parameter int LEVEL_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lbmd_pkg::lane_ctl_t               ctl,
    input  logic signed [LEVEL_BITS-1:0]      level,
    input  logic signed [LEVEL_BITS-1:0]      thr,
    output logic [$clog2(NUM_LEDS + 1)-1:0]   count
);

    import lbmd_pkg::*;

    localparam int CW = $clog2(NUM_LEDS + 1);

    logic signed [LEVEL_BITS-1:0] level_reg;
    logic                         alive_reg;
    logic                         alive_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;

    // count = number of leading thresholds the level strictly exceeds
    always_comb
    begin
        alive_next = alive_reg;
        count_next = count_reg;
        if (ctl.start)
        begin
            alive_next = 1'b1;
            count_next = '0;
        end
        else if (ctl.step && alive_reg)
        begin
            if (level_reg > thr)
            begin
                count_next = count_reg + CW'(1);
            end
            else
            begin
                alive_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            level_reg <= level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            alive_reg <= alive_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

### hdl/lbmd_merge.sv
module lbmd_merge #(
    parameter int NUM_LEDS = 36
) (
    input  logic [lbmd_pkg::MODE_W-1:0]                     mode,
    input  logic [$clog2(NUM_LEDS + 1)-1:0]                 vu_l,
    input  logic [$clog2(NUM_LEDS + 1)-1:0]                 vu_r,
    input  logic [$clog2(NUM_LEDS + 1)-1:0]                 ppm_l,
    input  logic [$clog2(NUM_LEDS + 1)-1:0]                 ppm_r,
    input  logic [((NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1)-1:0] pos,
    input  logic [lbmd_pkg::COLOR_W-1:0]                    bg,
    input  logic [lbmd_pkg::COLOR_W-1:0]                    bar,
    input  logic [lbmd_pkg::COLOR_W-1:0]                    dot,
    output logic [lbmd_pkg::COLOR_W-1:0]                    color_left,
    output logic [lbmd_pkg::COLOR_W-1:0]                    color_right
);

    import lbmd_pkg::*;

    localparam int CW = $clog2(NUM_LEDS + 1);

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] pos_inc;
    logic bar_vl, bar_vr, bar_pl, bar_pr;
    logic dot_vl, dot_vr, dot_pl, dot_pr;

    // Segment >= pos is count > pos; segment == pos is count == pos + 1
    assign pos_ext = CW'(pos);
    assign pos_inc = pos_ext + CW'(1);

    assign bar_vl = vu_l  > pos_ext;
    assign bar_vr = vu_r  > pos_ext;
    assign bar_pl = ppm_l > pos_ext;
    assign bar_pr = ppm_r > pos_ext;
    assign dot_vl = vu_l  == pos_inc;
    assign dot_vr = vu_r  == pos_inc;
    assign dot_pl = ppm_l == pos_inc;
    assign dot_pr = ppm_r == pos_inc;

    always_comb
    begin
        case (mode)
            MODE_VU_BAR:
            begin
                color_left  = bar_vl ? bar : bg;
                color_right = bar_vr ? bar : bg;
            end
            MODE_VU_DOT:
            begin
                color_left  = dot_vl ? dot : bg;
                color_right = dot_vr ? dot : bg;
            end
            MODE_PPM_BAR:
            begin
                color_left  = bar_pl ? bar : bg;
                color_right = bar_pr ? bar : bg;
            end
            MODE_PPM_DOT:
            begin
                color_left  = dot_pl ? dot : bg;
                color_right = dot_pr ? dot : bg;
            end
            default:
            begin
                // PPM dot drawn over the VU bar; unused codes land here too
                color_left  = dot_pl ? dot : (bar_vl ? bar : bg);
                color_right = dot_pr ? dot : (bar_vr ? bar : bg);
            end
        endcase
    end

endmodule

### tb/sv/lbmd_frame_checker.sv
module lbmd_frame_checker #(
    parameter int NUM_LEDS = 36
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lbmd_pkg::PADDR_W-1:0]        paddr,
    input  logic [lbmd_pkg::PDATA_W-1:0]        pwdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [lbmd_pkg::REQ_W-1:0]          req_type,
    input  logic [lbmd_pkg::POS_W-1:0]          table_index,
    input  logic [lbmd_pkg::COLOR_W-1:0]        load_word,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] vu_left,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] vu_right,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] ppm_left,
    input  logic signed [lbmd_pkg::LEVEL_W-1:0] ppm_right,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [lbmd_pkg::POS_W-1:0]          led_position,
    input  logic [lbmd_pkg::COLOR_W-1:0]        color_left,
    input  logic [lbmd_pkg::COLOR_W-1:0]        color_right,
    input  logic [lbmd_pkg::BRIGHT_W-1:0]       global_brightness,
    input  logic                                last_led,
    output int                                  fail_count,
    output int                                  led_words_due,
    output int                                  led_words_seen
);

    import lbmd_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [COLOR_W-1:0]  left;
        logic [COLOR_W-1:0]  right;
        logic [BRIGHT_W-1:0] bright;
        logic                last;
    } led_word_t;

    led_word_t                 led_queue [$];
    logic signed [LEVEL_W-1:0] thresholds [NUM_LEDS];
    logic [COLOR_W-1:0]        bg_colour [NUM_LEDS];
    logic [COLOR_W-1:0]        bar_colour [NUM_LEDS];
    logic [COLOR_W-1:0]        dot_colour [NUM_LEDS];
    logic [MODE_W-1:0]         mode_reg;
    logic signed [OFFS_W-1:0]  offset_reg;
    int                        fails = 0;
    int                        seen = 0;

    // count of leading thresholds strictly exceeded, minus one
    function automatic int segment_for(logic signed [LEVEL_W-1:0] level);
        int n;
        n = 0;
        while (n < NUM_LEDS && level > thresholds[n])
            n++;
        return n - 1;
    endfunction

    function automatic logic [COLOR_W-1:0] bar_at(int seg, int p);
        return (seg >= p) ? bar_colour[p] : bg_colour[p];
    endfunction

    function automatic logic [COLOR_W-1:0] dot_at(int seg, int p);
        return (seg == p) ? dot_colour[p] : bg_colour[p];
    endfunction

    task automatic paint_frame(input logic signed [LEVEL_W-1:0] vl, vr, pl, pr);
        int        seg_vl;
        int        seg_vr;
        int        seg_pl;
        int        seg_pr;
        int        b;
        led_word_t w;
        seg_vl = segment_for(vl);
        seg_vr = segment_for(vr);
        seg_pl = segment_for(pl);
        seg_pr = segment_for(pr);
        b = int'(BASE_BRIGHTNESS) + int'(offset_reg);
        if (b < 0)
            b = 0;
        if (b > 255)
            b = 255;
        for (int p = 0; p < NUM_LEDS; p++)
        begin
            w.pos = p[POS_W-1:0];
            w.bright = b[BRIGHT_W-1:0];
            w.last = (p == NUM_LEDS - 1);
            case (mode_reg)
                MODE_VU_BAR:
                begin
                    w.left = bar_at(seg_vl, p);
                    w.right = bar_at(seg_vr, p);
                end
                MODE_VU_DOT:
                begin
                    w.left = dot_at(seg_vl, p);
                    w.right = dot_at(seg_vr, p);
                end
                MODE_PPM_BAR:
                begin
                    w.left = bar_at(seg_pl, p);
                    w.right = bar_at(seg_pr, p);
                end
                MODE_PPM_DOT:
                begin
                    w.left = dot_at(seg_pl, p);
                    w.right = dot_at(seg_pr, p);
                end
                default:
                begin
                    // peak dot drawn over the VU bar; spare codes land here too
                    w.left = (seg_pl == p) ? dot_colour[p] : bar_at(seg_vl, p);
                    w.right = (seg_pr == p) ? dot_colour[p] : bar_at(seg_vr, p);
                end
            endcase
            led_queue.push_back(w);
        end
    endtask

    task automatic check_field(input string field, input logic [COLOR_W-1:0] want, got);
        if (want !== got)
        begin
            $display("%0t: %s expected 'h%0h, got 'h%0h", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        led_word_t want;
        if (!rst_n)
        begin
            mode_reg = MODE_PPM_DOT_VU_BAR;
            offset_reg = '0;
            led_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_DISPLAY_MODE)
                    mode_reg = pwdata[MODE_W-1:0];
                else
                    offset_reg = pwdata[OFFS_W-1:0];
            end

            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_FRAME)
                    paint_frame(vu_left, vu_right, ppm_left, ppm_right);
                else if (table_index < NUM_LEDS)
                begin
                    case (req_type)
                        REQ_THRESHOLD:  thresholds[table_index] = load_word[LEVEL_W-1:0];
                        REQ_BACKGROUND: bg_colour[table_index] = load_word;
                        REQ_BAR:        bar_colour[table_index] = load_word;
                        REQ_DOT:        dot_colour[table_index] = load_word;
                        default:        ;
                    endcase
                end
            end

            if (out_valid && !out_stall)
            begin
                if (led_queue.size() == 0)
                begin
                    $display("%0t: LED word at position %0d with none expected",
                             $time, led_position);
                    fails++;
                end
                else
                begin
                    want = led_queue.pop_front();
                    check_field("led_position", COLOR_W'(want.pos), COLOR_W'(led_position));
                    check_field("color_left", want.left, color_left);
                    check_field("color_right", want.right, color_right);
                    check_field("global_brightness", COLOR_W'(want.bright),
                                COLOR_W'(global_brightness));
                    check_field("last_led", COLOR_W'(want.last), COLOR_W'(last_led));
                    seen++;
                end
            end
        end
        fail_count <= fails;
        led_words_due <= led_queue.size();
        led_words_seen <= seen;
    end

endmodule

### tb/sv/tb_led_bargraph_meter_drive.sv
module tb_led_bargraph_meter_drive;

    import lbmd_pkg::*;

    localparam int LEDS        = 36;
    localparam int PHASES      = 10;
    localparam int CALM_PHASE  = 8;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [REQ_W-1:0]  REQ_SPARE_LO   = 3'd5;
    localparam logic [REQ_W-1:0]  REQ_SPARE_MID  = 3'd6;
    localparam logic [REQ_W-1:0]  REQ_SPARE_HI   = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [REQ_W-1:0]          req_type = REQ_FRAME;
    logic [POS_W-1:0]          table_index = '0;
    logic [COLOR_W-1:0]        load_word = '0;
    logic signed [LEVEL_W-1:0] vu_left = '0;
    logic signed [LEVEL_W-1:0] vu_right = '0;
    logic signed [LEVEL_W-1:0] ppm_left = '0;
    logic signed [LEVEL_W-1:0] ppm_right = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [POS_W-1:0]          led_position;
    logic [COLOR_W-1:0]        color_left;
    logic [COLOR_W-1:0]        color_right;
    logic [BRIGHT_W-1:0]       global_brightness;
    logic                      last_led;
    int                        fail_count;
    int                        led_words_due;
    int                        led_words_seen;

    bit                        calm = 1'b0;
    int                        cycles = 0;
    int                        frames_sent = 0;
    int                        loads_sent = 0;
    int                        ignored_sent = 0;
    logic signed [LEVEL_W-1:0] thr_plan [LEDS];

    logic [MODE_W-1:0] phase_mode [8] = '{MODE_PPM_DOT_VU_BAR, MODE_VU_BAR, MODE_VU_DOT,
                                          MODE_PPM_BAR, MODE_PPM_DOT, MODE_SPARE_LO,
                                          MODE_SPARE_MID, MODE_SPARE_HI};
    logic [OFFS_W-1:0] phase_offset [8] = '{8'sd0, 8'sd56, -8'sd98, 8'sh80,
                                            8'sd127, -8'sd1, 8'sd1, 8'sd20};

    led_bargraph_meter_drive dut (.*);

    lbmd_frame_checker #(.NUM_LEDS(LEDS)) u_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit, %0d LED words still due", led_words_due);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver back-pressure in bursts, dropped altogether once calm
    initial
    begin : stall_pattern
        int   stall_left;
        logic stall_now;
        stall_left = 0;
        stall_now = 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
                out_stall <= 1'b0;
            else
            begin
                if (stall_left == 0)
                begin
                    stall_now = 1'($urandom_range(0, 1));
                    stall_left = $urandom_range(1, 16);
                end
                out_stall <= stall_now;
                stall_left--;
            end
        end
    end

    task automatic push_word(input logic [REQ_W-1:0] req, input int idx,
                             input logic [31:0] word,
                             input logic [31:0] vl, vr, pl, pr);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        req_type <= req;
        table_index <= idx[POS_W-1:0];
        load_word <= word[COLOR_W-1:0];
        vu_left <= vl[LEVEL_W-1:0];
        vu_right <= vr[LEVEL_W-1:0];
        ppm_left <= pl[LEVEL_W-1:0];
        ppm_right <= pr[LEVEL_W-1:0];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (req == REQ_FRAME)
            frames_sent++;
        else if (req <= REQ_DOT && idx >= 0 && idx < LEDS)
            loads_sent++;
        else
            ignored_sent++;
    endtask

    task automatic send_levels(input logic [31:0] vl, vr, pl, pr);
        push_word(REQ_FRAME, int'($urandom), $urandom, vl, vr, pl, pr);
    endtask

    // drop valid and wait for the block to drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (led_words_due != 0)
            @(posedge clk);
        repeat (2 * LEDS + 8) @(posedge clk);
    endtask

    task automatic apb_write(input logic idx, input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apply_setting(input logic [MODE_W-1:0] m, input logic [OFFS_W-1:0] o);
        apply_mode: apb_write(REG_DISPLAY_MODE, {{(PDATA_W-MODE_W){1'b0}}, m});
        apb_write(REG_BRIGHTNESS_OFFSET, {{(PDATA_W-OFFS_W){o[OFFS_W-1]}}, o});
    endtask

    // shapes: spread ascending, ascending with both extremes, scattered
    task automatic load_thresholds(input int shape);
        int v;
        for (int i = 0; i < LEDS; i++)
        begin
            case (shape)
                0:       v = -12000 + i * 600 + $urandom_range(0, 99);
                1:       v = (i == 0) ? -32768 : (i == LEDS - 1) ? 32767
                             : -30000 + i * 1700 + $urandom_range(0, 99);
                default: v = $urandom;
            endcase
            thr_plan[i] = v[LEVEL_W-1:0];
            push_word(REQ_THRESHOLD, i, {16'($urandom), v[LEVEL_W-1:0]},
                      $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic load_colours();
        for (int i = 0; i < LEDS; i++)
        begin
            push_word(REQ_BACKGROUND, i, $urandom, $urandom, $urandom, $urandom, $urandom);
            push_word(REQ_BAR, i, $urandom, $urandom, $urandom, $urandom, $urandom);
            push_word(REQ_DOT, i, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // mostly levels on or beside a randomly picked threshold
    function automatic logic [31:0] pick_level();
        int sel;
        int j;
        sel = $urandom_range(0, 9);
        j = $urandom_range(0, LEDS - 1);
        case (sel)
            0:       return $urandom;
            1:       return 32'h8000;
            2:       return 32'h7FFF;
            default: return 32'(thr_plan[j]) + $urandom_range(0, 2) - 1;
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_load();
        case ($urandom_range(0, 3))
            0:       return REQ_THRESHOLD;
            1:       return REQ_BACKGROUND;
            2:       return REQ_BAR;
            default: return REQ_DOT;
        endcase
    endfunction

    task automatic directed_words();
        logic [REQ_W-1:0] r;
        send_levels(32'h8000, 32'h8000, 32'h8000, 32'h8000);
        send_levels(32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF);
        // equal to a threshold does not light it, one above does
        send_levels(32'(thr_plan[5]), 32'(thr_plan[5]) + 1, 32'(thr_plan[0]),
                    32'(thr_plan[LEDS-1]) + 1);
        send_levels(32'(thr_plan[10]) + 1, 32'(thr_plan[20]) + 1, 32'(thr_plan[10]) + 1,
                    32'(thr_plan[3]) + 1);
        send_levels('0, '0, '0, '0);
        push_word(REQ_SPARE_LO, int'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom);
        push_word(REQ_SPARE_MID, int'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom);
        push_word(REQ_SPARE_HI, int'($urandom), $urandom, $urandom, $urandom, $urandom,
                  $urandom);
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0:       r = REQ_THRESHOLD;
                1:       r = REQ_BACKGROUND;
                2:       r = REQ_BAR;
                default: r = REQ_DOT;
            endcase
            push_word(r, LEDS, $urandom, $urandom, $urandom, $urandom, $urandom);
            push_word(r, 63, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        // tables must be untouched by the dropped loads
        send_levels(pick_level(), pick_level(), pick_level(), pick_level());
    endtask

    task automatic random_words(input int n);
        int                 done;
        int                 kind;
        int                 i;
        int                 v;
        logic [REQ_W-1:0]   r;
        done = 0;
        while (done < n)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                send_levels(pick_level(), pick_level(), pick_level(), pick_level());
                done++;
            end
            else if (kind < 16)
            begin
                case ($urandom_range(0, 2))
                    0:       r = REQ_BACKGROUND;
                    1:       r = REQ_BAR;
                    default: r = REQ_DOT;
                endcase
                push_word(r, $urandom_range(0, LEDS - 1), $urandom,
                          $urandom, $urandom, $urandom, $urandom);
                done++;
            end
            else if (kind == 16)
            begin
                i = $urandom_range(0, LEDS - 1);
                v = thr_plan[i] + $urandom_range(0, 64) - 32;
                thr_plan[i] = v[LEVEL_W-1:0];
                push_word(REQ_THRESHOLD, i, {16'($urandom), v[LEVEL_W-1:0]},
                          $urandom, $urandom, $urandom, $urandom);
                done++;
            end
            else if (kind == 17)
            begin
                case ($urandom_range(0, 2))
                    0:       r = REQ_SPARE_LO;
                    1:       r = REQ_SPARE_MID;
                    default: r = REQ_SPARE_HI;
                endcase
                push_word(r, int'($urandom), $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            end
            else if (kind == 18)
                push_word(pick_load(), $urandom_range(LEDS, 63), $urandom,
                          $urandom, $urandom, $urandom, $urandom);
            else
            begin
                send_levels($urandom, $urandom, $urandom, $urandom);
                done++;
            end
        end
    endtask

    initial
    begin
        logic [MODE_W-1:0] m;
        logic [OFFS_W-1:0] o;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm = (ph >= CALM_PHASE);
            settle();
            if (ph < 8)
            begin
                m = phase_mode[ph];
                o = phase_offset[ph];
            end
            else
            begin
                m = MODE_W'($urandom_range(0, 7));
                o = OFFS_W'($urandom);
            end
            apply_setting(m, o);
            if (ph == 0)
            begin
                load_thresholds(0);
                load_colours();
                directed_words();
            end
            if (ph == 4)
                load_thresholds(1);
            if (ph == 7)
                load_thresholds(2);
            random_words(7);
        end
        settle();

        $display("Drove %0d level frames and %0d table loads across %0d mode/brightness settings",
                 frames_sent, loads_sent, PHASES);
        $display("%0d dropped words, %0d LED words compared, %0d mismatches",
                 ignored_sent, led_words_seen, fail_count);
        if (fail_count == 0 && led_words_due == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
